/* rtl/core/wavdm_pkg.sv */
// Shared types, codes and constants for the WAV header parser with stereo downmix.
// Used by wavdm_core and the top level wav_header_parse_stereo_downmix.
package wavdm_pkg;

  localparam int unsigned HdrLen = 44;
  localparam logic [5:0] LastHdrOffset = 6'(HdrLen - 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_RIFF      = 3'd0;
  localparam logic [2:0] ERR_WAVE      = 3'd1;
  localparam logic [2:0] ERR_FMT       = 3'd2;
  localparam logic [2:0] ERR_DATA      = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [15:0]        sample_bits;
    logic [29:0]        sample_count;
    logic [2:0]         error_code;
  } res_t;

  // Expected characters of the four tags: RIFF, WAVE, "fmt " and data.
  function automatic logic [7:0] tag_char(input logic [1:0] slot, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case ({slot, pos})
      4'h0: c = 8'h52;
      4'h1: c = 8'h49;
      4'h2: c = 8'h46;
      4'h3: c = 8'h46;
      4'h4: c = 8'h57;
      4'h5: c = 8'h41;
      4'h6: c = 8'h56;
      4'h7: c = 8'h45;
      4'h8: c = 8'h66;
      4'h9: c = 8'h6D;
      4'hA: c = 8'h74;
      4'hB: c = 8'h20;
      4'hC: c = 8'h64;
      4'hD: c = 8'h61;
      4'hE: c = 8'h74;
      4'hF: c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/wavdm_core.sv */
// Parser state and per-byte logic: header checks and captures, frame gathering and downmix.
// Depends on wavdm_pkg.
module wavdm_core
  import wavdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       res_valid,
  output res_t       res
);

  logic [5:0]  byte_offset, byte_offset_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] channel_count_reg, channel_count_reg_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [15:0] bits_reg, bits_reg_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [23:0] frame_bytes, frame_bytes_next;
  logic [1:0]  frame_position, frame_position_next;

  logic               is_tag;
  logic [1:0]         slot;
  logic               bad;
  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;

  always_comb begin
    is_tag = 1'b1;
    slot   = 2'd0;
    priority if (byte_offset <= 6'd3) begin
      slot = 2'd0;
    end else if (byte_offset >= 6'd8 && byte_offset <= 6'd11) begin
      slot = 2'd1;
    end else if (byte_offset >= 6'd12 && byte_offset <= 6'd15) begin
      slot = 2'd2;
    end else if (byte_offset >= 6'd36 && byte_offset <= 6'd39) begin
      slot = 2'd3;
    end else begin
      is_tag = 1'b0;
    end
    bad = is_tag && (tag_char(slot, byte_offset[1:0]) != data_byte);

    sum = {frame_bytes[15], frame_bytes[15:0]} + {data_byte[7], data_byte, frame_bytes[23:16]};
    // Adding one to a negative sum before the shift truncates toward zero.
    sum_adj = sum + {16'd0, sum[16]};
  end

  always_comb begin
    byte_offset_next       = byte_offset;
    phase_next             = phase;
    channel_count_reg_next = channel_count_reg;
    rate_reg_next          = rate_reg;
    bits_reg_next          = bits_reg;
    data_remaining_next    = data_remaining;
    frame_bytes_next       = frame_bytes;
    frame_position_next    = frame_position;
    res_valid              = 1'b0;
    res                    = '0;

    unique case (phase)
      PH_HEADER: begin
        unique case (byte_offset)
          6'd22: channel_count_reg_next[7:0]  = data_byte;
          6'd23: channel_count_reg_next[15:8] = data_byte;
          6'd24: rate_reg_next[7:0]           = data_byte;
          6'd25: rate_reg_next[15:8]          = data_byte;
          6'd26: rate_reg_next[23:16]         = data_byte;
          6'd27: rate_reg_next[31:24]         = data_byte;
          6'd34: bits_reg_next[7:0]           = data_byte;
          6'd35: bits_reg_next[15:8]          = data_byte;
          6'd40: data_remaining_next[7:0]     = data_byte;
          6'd41: data_remaining_next[15:8]    = data_byte;
          6'd42: data_remaining_next[23:16]   = data_byte;
          6'd43: data_remaining_next[31:24]   = data_byte;
          default: begin
          end
        endcase
        priority if (bad) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = {1'b0, slot};
          phase_next     = PH_SKIP;
        end else if (byte_offset == LastHdrOffset) begin
          res_valid           = 1'b1;
          res.kind            = KIND_HEADER;
          res.channels        = channel_count_reg;
          res.sample_rate     = rate_reg;
          res.sample_bits     = bits_reg;
          res.sample_count    = {data_byte, data_remaining[23:2]};
          phase_next          = PH_DATA;
          frame_bytes_next    = '0;
          frame_position_next = '0;
        end else if (stream_end) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
        end else begin
          byte_offset_next = byte_offset + 6'd1;
        end
      end
      PH_DATA: begin
        if (data_remaining != 32'd0) begin
          data_remaining_next = data_remaining - 32'd1;
          if (frame_position != 2'd3) begin
            unique case (frame_position)
              2'd0:    frame_bytes_next[7:0]   = data_byte;
              2'd1:    frame_bytes_next[15:8]  = data_byte;
              default: frame_bytes_next[23:16] = data_byte;
            endcase
            frame_position_next = frame_position + 2'd1;
          end else begin
            res_valid           = 1'b1;
            res.kind            = KIND_SAMPLE;
            res.sample          = sum_adj[16:1];
            frame_bytes_next    = '0;
            frame_position_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && stream_end)) begin
      byte_offset       <= '0;
      phase             <= PH_HEADER;
      channel_count_reg <= '0;
      rate_reg          <= '0;
      bits_reg          <= '0;
      data_remaining    <= '0;
      frame_bytes       <= '0;
      frame_position    <= '0;
    end else if (fire) begin
      byte_offset       <= byte_offset_next;
      phase             <= phase_next;
      channel_count_reg <= channel_count_reg_next;
      rate_reg          <= rate_reg_next;
      bits_reg          <= bits_reg_next;
      data_remaining    <= data_remaining_next;
      frame_bytes       <= frame_bytes_next;
      frame_position    <= frame_position_next;
    end
  end

endmodule

/* rtl/core/wav_header_parse_stereo_downmix.sv */
// Top level of the WAV header parser with stereo-to-mono downmix.
// Depends on wavdm_pkg and wavdm_core.
//
// The block takes one byte of a WAV file per request and sustains one byte per
// cycle while results are accepted. A taken byte is held in the input register, the single pass of
// the parser logic runs on it, and its result is registered into the result
// register and presented from there; a result held back by out_ready
// stalls the parser, and input stops once the input register is full as well.
// Each byte gives at most one result: a header result on byte 43, an error on
// a tag mismatch or an early end, or a mono sample on the last byte of each
// 4-byte stereo frame. The byte marked stream_end returns the parser to its
// reset state.
module wav_header_parse_stereo_downmix
  import wavdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] sample,
  output logic [15:0]        channels,
  output logic [31:0]        sample_rate,
  output logic [15:0]        sample_bits,
  output logic [29:0]        sample_count,
  output logic [2:0]         error_code
);

  logic       in_held;
  logic [7:0] byte_reg;
  logic       end_reg;
  logic       advance;
  logic       fire;
  logic       res_valid;
  res_t       res;
  res_t       out_reg;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_held || advance;
  assign fire     = in_held && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= data_byte;
      end_reg  <= stream_end;
    end
  end

  wavdm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (byte_reg),
    .stream_end (end_reg),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign kind         = out_reg.kind;
  assign sample       = out_reg.sample;
  assign channels     = out_reg.channels;
  assign sample_rate  = out_reg.sample_rate;
  assign sample_bits  = out_reg.sample_bits;
  assign sample_count = out_reg.sample_count;
  assign error_code   = out_reg.error_code;

endmodule

/* rtl/core/wavdm_checker.sv */
// Port-level checker for wav_header_parse_stereo_downmix, with its bind statement.
// Depends on wavdm_pkg.
module wavdm_checker
  import wavdm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic signed [15:0] sample,
  input logic [15:0]        channels,
  input logic [31:0]        sample_rate,
  input logic [15:0]        sample_bits,
  input logic [29:0]        sample_count,
  input logic [2:0]         error_code
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sample)
      && $stable(error_code) && $stable(sample_count))
    else $error("Result changed while stalled.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_SAMPLE || kind == KIND_HEADER || kind == KIND_ERROR)
    else $error("Illegal result kind.");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> error_code <= ERR_TRUNCATED && sample == 16'sd0
      && channels == 16'd0 && sample_count == 30'd0)
    else $error("Malformed error result.");

  a_sample_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SAMPLE |-> channels == 16'd0 && sample_rate == 32'd0
      && sample_bits == 16'd0 && error_code == 3'd0)
    else $error("Malformed sample result.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind wav_header_parse_stereo_downmix wavdm_checker u_wavdm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .sample       (sample),
  .channels     (channels),
  .sample_rate  (sample_rate),
  .sample_bits  (sample_bits),
  .sample_count (sample_count),
  .error_code   (error_code)
);

/* test/wav_header_parse_stereo_downmix_test.sv */
// Self-checking testbench for wav_header_parse_stereo_downmix: feeds WAV files a byte at a
// time, both well-formed and broken, and compares every result against a local parser model.
// Depends on wavdm_pkg for the result layout, kinds and error codes.
module wav_header_parse_stereo_downmix_test;
  import wavdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;
  localparam int LiveByteTarget = 1700;

  localparam logic [7:0] TAG_BYTES [16] = '{
    8'h52, 8'h49, 8'h46, 8'h46,
    8'h57, 8'h41, 8'h56, 8'h45,
    8'h66, 8'h6D, 8'h74, 8'h20,
    8'h64, 8'h61, 8'h74, 8'h61
  };
  localparam logic [2:0] TAG_ERRORS [4] = '{ERR_RIFF, ERR_WAVE, ERR_FMT, ERR_DATA};

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    logic [2:0] code;
  } dir_row_t;

  localparam int DirRows = 27;
  localparam dir_row_t DIRECTED_ROWS [DirRows] = '{
    '{8'h52, 1'b1, 1'b1, ERR_TRUNCATED},
    '{8'h58, 1'b1, 1'b1, ERR_RIFF},
    '{8'h52, 1'b0, 1'b0, ERR_RIFF},
    '{8'h49, 1'b0, 1'b0, ERR_RIFF},
    '{8'h46, 1'b0, 1'b0, ERR_RIFF},
    '{8'h47, 1'b0, 1'b1, ERR_RIFF},
    '{8'h00, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b1, 1'b0, ERR_RIFF},
    '{8'h52, 1'b0, 1'b0, ERR_RIFF},
    '{8'h49, 1'b0, 1'b0, ERR_RIFF},
    '{8'h46, 1'b0, 1'b0, ERR_RIFF},
    '{8'h46, 1'b0, 1'b0, ERR_RIFF},
    '{8'h00, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b0, 1'b0, ERR_RIFF},
    '{8'h00, 1'b1, 1'b1, ERR_TRUNCATED},
    '{8'h00, 1'b0, 1'b1, ERR_RIFF},
    '{8'hFF, 1'b1, 1'b0, ERR_RIFF},
    '{8'h52, 1'b0, 1'b0, ERR_RIFF},
    '{8'h49, 1'b0, 1'b0, ERR_RIFF},
    '{8'h46, 1'b0, 1'b0, ERR_RIFF},
    '{8'h46, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b0, 1'b0, ERR_RIFF},
    '{8'hFF, 1'b0, 1'b0, ERR_RIFF},
    '{8'h57, 1'b0, 1'b0, ERR_RIFF},
    '{8'h42, 1'b1, 1'b1, ERR_WAVE}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               stream_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [15:0]        channels;
  logic [31:0]        sample_rate;
  logic [15:0]        sample_bits;
  logic [29:0]        sample_count;
  logic [2:0]         error_code;

  wav_header_parse_stereo_downmix dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .sample       (sample),
    .channels     (channels),
    .sample_rate  (sample_rate),
    .sample_bits  (sample_bits),
    .sample_count (sample_count),
    .error_code   (error_code)
  );

  res_t       queued_parse_results [$];
  logic [7:0] file_buf [$];
  int         error_count = 0;
  int         live_bytes = 0;
  int         stall_cycles = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;
  int         ready_hold = 0;

  logic [5:0]  hdr_offset;
  logic [1:0]  parse_phase;
  logic [15:0] chan_acc;
  logic [31:0] rate_acc;
  logic [15:0] bits_acc;
  logic [31:0] data_left;
  logic [23:0] frame_acc;
  logic [1:0]  frame_idx;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_parser();
    hdr_offset  = '0;
    parse_phase = PH_HEADER;
    chan_acc    = '0;
    rate_acc    = '0;
    bits_acc    = '0;
    data_left   = '0;
    frame_acc   = '0;
    frame_idx   = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last, output bit got,
                            output res_t r);
    int off;
    int slot;
    int mono;
    logic signed [15:0] left;
    logic signed [15:0] right;
    got = 1'b0;
    r = '0;
    off = int'(hdr_offset);
    if (parse_phase == PH_HEADER) begin
      slot = -1;
      if (off <= 3) begin
        slot = 0;
      end else if (off >= 8 && off <= 11) begin
        slot = 1;
      end else if (off >= 12 && off <= 15) begin
        slot = 2;
      end else if (off >= 36 && off <= 39) begin
        slot = 3;
      end
      if (off == 22 || off == 23) begin
        chan_acc[(off - 22) * 8 +: 8] = b;
      end else if (off >= 24 && off <= 27) begin
        rate_acc[(off - 24) * 8 +: 8] = b;
      end else if (off == 34 || off == 35) begin
        bits_acc[(off - 34) * 8 +: 8] = b;
      end else if (off >= 40) begin
        data_left[(off - 40) * 8 +: 8] = b;
      end
      if (slot >= 0 && TAG_BYTES[slot * 4 + off % 4] != b) begin
        got = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = TAG_ERRORS[slot];
        parse_phase = PH_SKIP;
      end else if (hdr_offset == LastHdrOffset) begin
        got = 1'b1;
        r.kind = KIND_HEADER;
        r.channels = chan_acc;
        r.sample_rate = rate_acc;
        r.sample_bits = bits_acc;
        r.sample_count = data_left[31:2];
        parse_phase = PH_DATA;
        frame_acc = '0;
        frame_idx = '0;
      end else if (last) begin
        got = 1'b1;
        r.kind = KIND_ERROR;
        r.error_code = ERR_TRUNCATED;
      end else begin
        hdr_offset = hdr_offset + 6'd1;
      end
    end else if (parse_phase == PH_DATA && data_left != 0) begin
      data_left = data_left - 32'd1;
      if (frame_idx < 2'd3) begin
        frame_acc[int'(frame_idx) * 8 +: 8] = b;
        frame_idx = frame_idx + 2'd1;
      end else begin
        left = frame_acc[15:0];
        right = {b, frame_acc[23:16]};
        mono = (int'(left) + int'(right)) / 2;
        got = 1'b1;
        r.kind = KIND_SAMPLE;
        r.sample = 16'(mono);
        frame_acc = '0;
        frame_idx = '0;
      end
    end
    if (last) begin
      clear_parser();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input logic [2:0] code);
    int gap;
    bit got;
    res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    stream_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (parse_phase == PH_HEADER || (parse_phase == PH_DATA && data_left != 0)) begin
      live_bytes++;
    end
    parse_byte(b, last, got, r);
    if (typed) begin
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      got = 1'b1;
    end
    if (got) begin
      queued_parse_results.push_back(r);
    end
  endtask

  task automatic add16(input logic [15:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
  endtask

  task automatic add32(input logic [31:0] v);
    add16(v[15:0]);
    add16(v[31:16]);
  endtask

  task automatic build_header(input logic [31:0] size);
    for (int i = 0; i < 4; i++) file_buf.push_back(TAG_BYTES[i]);
    add32($urandom);
    for (int i = 4; i < 12; i++) file_buf.push_back(TAG_BYTES[i]);
    for (int i = 0; i < 6; i++) file_buf.push_back(8'($urandom));
    add16(($urandom_range(0, 1) == 0) ? 16'd2 : 16'($urandom));
    case ($urandom_range(0, 2))
      0: add32(32'd44100);
      1: add32(32'd48000);
      default: add32($urandom);
    endcase
    for (int i = 0; i < 6; i++) file_buf.push_back(8'($urandom));
    add16(($urandom_range(0, 1) == 0) ? 16'd16 : 16'($urandom));
    for (int i = 12; i < 16; i++) file_buf.push_back(TAG_BYTES[i]);
    add32(size);
  endtask

  function automatic logic [7:0] pick_sample_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h80;
        default: return 8'h7F;
      endcase
    end
    return 8'($urandom);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin : ready_gen
    int g;
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        ready_hold = g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (queued_parse_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d sample %0d code %0d", $time, kind, sample,
                 error_code);
        error_count++;
      end else begin
        want = queued_parse_results.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d, actual %0d", $time, want.kind, kind);
          error_count++;
        end
        if (sample !== want.sample) begin
          $display("%0t: sample expected %0d, actual %0d", $time, want.sample, sample);
          error_count++;
        end
        if (channels !== want.channels) begin
          $display("%0t: channels expected %0d, actual %0d", $time, want.channels, channels);
          error_count++;
        end
        if (sample_rate !== want.sample_rate) begin
          $display("%0t: sample_rate expected %0d, actual %0d", $time, want.sample_rate,
                   sample_rate);
          error_count++;
        end
        if (sample_bits !== want.sample_bits) begin
          $display("%0t: sample_bits expected %0d, actual %0d", $time,
                   want.sample_bits, sample_bits);
          error_count++;
        end
        if (sample_count !== want.sample_count) begin
          $display("%0t: sample_count expected %0d, actual %0d", $time, want.sample_count,
                   sample_count);
          error_count++;
        end
        if (error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d, actual %0d", $time, want.error_code,
                   error_code);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int choice;
    int count;
    int idx;
    int off;
    int keep;
    logic [31:0] size;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++) begin
      send_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].code);
    end

    while (live_bytes < LiveByteTarget) begin
      file_buf.delete();
      choice = $urandom_range(0, 99);
      size = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(0, 48)) : $urandom;
      build_header(size);
      if (choice < 70) begin
        if (size > 48) begin
          count = $urandom_range(0, 24);
        end else begin
          count = int'(size);
          case ($urandom_range(0, 4))
            0: count = $urandom_range(0, int'(size));
            1: count = count + $urandom_range(1, 6);
            default: ;
          endcase
        end
        for (int i = 0; i < count; i++) file_buf.push_back(pick_sample_byte());
      end else if (choice < 85) begin
        idx = $urandom_range(0, 15);
        off = (idx < 4) ? idx : ((idx < 12) ? idx + 4 : idx + 24);
        file_buf[off] = file_buf[off] ^ 8'($urandom_range(1, 255));
        keep = off + 1 + $urandom_range(0, 6);
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end else if (choice < 93) begin
        keep = $urandom_range(1, 43);
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end else begin
        file_buf.delete();
        count = $urandom_range(1, 12);
        for (int i = 0; i < count; i++) file_buf.push_back(8'($urandom));
      end
      for (int i = 0; i < file_buf.size(); i++) begin
        send_byte(file_buf[i], (i == file_buf.size() - 1), 1'b0, ERR_RIFF);
      end
    end

    in_valid <= 1'b0;
    while (queued_parse_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
